>>> hdl/gha_pkg.sv
// Shared types and command codes for the GHASH accumulator.
package gha_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned TOTAL_W = 61;
    localparam int unsigned INDEX_W = 2;

    typedef enum logic [1:0] {
        CMD_ABSORB = 2'd0,
        CMD_FINISH = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1
    } reg_index_t;

    // One transaction as held in the input register.
    typedef struct packed {
        cmd_t                 cmd;
        logic [BLOCK_W-1:0]   block;
        logic [COUNT_W-1:0]   byte_count;
    } item_t;

endpackage

>>> hdl/gha_gfmul.sv
// GF(2^128) multiplier in GCM bit order, modulus x^128 + x^7 + x^2 + x + 1.
module gha_gfmul
(
    input  logic [gha_pkg::BLOCK_W-1:0] a,
    input  logic [gha_pkg::BLOCK_W-1:0] b,
    output logic [gha_pkg::BLOCK_W-1:0] product
);
    import gha_pkg::*;

    logic [BLOCK_W-1:0]   a_rev;
    logic [BLOCK_W-1:0]   b_rev;
    logic [2*BLOCK_W-2:0] clmul;
    logic [BLOCK_W+5:0]   fold1;
    logic [12:0]          fold2;
    logic [BLOCK_W-1:0]   reduced;

    // GCM puts the coefficient of x^0 in the most significant bit.
    always_comb
    begin
        for (int i = 0; i < BLOCK_W; i++)
        begin
            a_rev[i] = a[BLOCK_W-1-i];
            b_rev[i] = b[BLOCK_W-1-i];
        end
    end

    // Carry-less product: every output bit is an XOR tree of partial products.
    always_comb
    begin
        clmul = '0;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            for (int j = 0; j < BLOCK_W; j++)
            begin
                clmul[i+j] = clmul[i+j] ^ (a_rev[i] & b_rev[j]);
            end
        end
    end

    // Fold the upper half twice with x^7 + x^2 + x + 1.
    always_comb
    begin
        fold1 = {7'b0, clmul[2*BLOCK_W-2:BLOCK_W]}
              ^ ({7'b0, clmul[2*BLOCK_W-2:BLOCK_W]} << 1)
              ^ ({7'b0, clmul[2*BLOCK_W-2:BLOCK_W]} << 2)
              ^ ({7'b0, clmul[2*BLOCK_W-2:BLOCK_W]} << 7);
        fold2 = {7'b0, fold1[BLOCK_W+5:BLOCK_W]}
              ^ ({7'b0, fold1[BLOCK_W+5:BLOCK_W]} << 1)
              ^ ({7'b0, fold1[BLOCK_W+5:BLOCK_W]} << 2)
              ^ ({7'b0, fold1[BLOCK_W+5:BLOCK_W]} << 7);
        reduced = clmul[BLOCK_W-1:0] ^ fold1[BLOCK_W-1:0]
                ^ {{(BLOCK_W-13){1'b0}}, fold2};
        for (int i = 0; i < BLOCK_W; i++)
        begin
            product[BLOCK_W-1-i] = reduced[i];
        end
    end

endmodule

>>> hdl/gha_state.sv
// Accumulator and byte-count state with the per-command update logic.
module gha_state
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  gha_pkg::item_t              item,
    input  logic [gha_pkg::BLOCK_W-1:0] hash_key,
    output logic [gha_pkg::BLOCK_W-1:0] result
);
    import gha_pkg::*;

    logic [BLOCK_W-1:0] acc_reg;
    logic [BLOCK_W-1:0] acc_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [COUNT_W-1:0] count_clamped;
    logic [BLOCK_W-1:0] byte_mask;
    logic [BLOCK_W-1:0] mul_in;
    logic [BLOCK_W-1:0] mul_out;

    // Counts above a full block mean a full block.
    assign count_clamped = (item.byte_count > COUNT_W'(16)) ? COUNT_W'(16) : item.byte_count;

    // Keep the leading bytes, zero the rest.
    always_comb
    begin
        for (int b = 0; b < 16; b++)
        begin
            byte_mask[BLOCK_W-1-8*b -: 8] = (COUNT_W'(b) < count_clamped) ? 8'hFF : 8'h00;
        end
    end

    always_comb
    begin
        if (item.cmd == CMD_FINISH)
        begin
            mul_in = acc_reg ^ {{HALF_W{1'b0}}, total_reg, 3'b000};
        end
        else
        begin
            mul_in = acc_reg ^ (item.block & byte_mask);
        end
    end

    gha_gfmul u_gfmul
    (
        .a       (mul_in),
        .b       (hash_key),
        .product (mul_out)
    );

    always_comb
    begin
        acc_next   = acc_reg;
        total_next = total_reg;
        result     = acc_reg;
        case (item.cmd)
            CMD_ABSORB:
            begin
                if (count_clamped != '0)
                begin
                    acc_next   = mul_out;
                    total_next = total_reg + TOTAL_W'(count_clamped);
                    result     = mul_out;
                end
            end
            CMD_FINISH:
            begin
                acc_next = mul_out;
                result   = mul_out ^ item.block;
            end
            CMD_CLEAR:
            begin
                acc_next   = '0;
                total_next = '0;
                result     = '0;
            end
            default:
            begin
                result = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            total_reg <= '0;
        end
        else if (step_en)
        begin
            acc_reg   <= acc_next;
            total_reg <= total_next;
        end
    end

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.cmd == CMD_CLEAR |=> acc_reg == '0 && total_reg == '0)
        else $error("clear left state nonzero");

    a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.cmd == CMD_ABSORB && item.byte_count == '0
        |=> $stable(acc_reg) && $stable(total_reg))
        else $error("empty block changed state");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(acc_reg) && $stable(total_reg))
        else $error("state moved without a step");

endmodule

>>> hdl/ghash_accumulator.sv
// Top level of the GHASH accumulator: handshake, key registers, pipeline.
//
// Usage:
//   Load the hash subkey H through the write port (index 0 = first 8 bytes,
//   index 1 = last 8 bytes, big-endian) while the block is idle. Then send
//   transactions on the input channel: cmd absorb folds a data block of
//   byte_count leading bytes into the accumulator, cmd finish folds in the
//   GCM length block and returns the tag xor the mask in block_high/low,
//   cmd clear zeroes the accumulator and the byte total.
//   Every input transaction yields exactly one output transaction.
// Timing:
//   An accepted transaction waits in the input register, where the
//   combinational GF(2^128) multiplier and state update run, and moves into
//   the result register, raising out_valid, once the result slot is free or
//   drains.
//   Throughput is one transaction per cycle while out_ready stays high; the
//   accumulator feedback through the multiplier sets the clock period.
// Reset:
//   rst_n clears the key, the accumulator, the byte total and both valids.
// Stall:
//   When out_ready is low with a result waiting, the input register holds its
//   transaction and in_ready drops once that register is full.
module ghash_accumulator
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [gha_pkg::INDEX_W-1:0]       cfg_index,
    input  logic [gha_pkg::HALF_W-1:0]        cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        cmd,
    input  logic [gha_pkg::HALF_W-1:0]        block_high,
    input  logic [gha_pkg::HALF_W-1:0]        block_low,
    input  logic [gha_pkg::COUNT_W-1:0]       byte_count,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [gha_pkg::HALF_W-1:0]        result_high,
    output logic [gha_pkg::HALF_W-1:0]        result_low
);
    import gha_pkg::*;

    logic [HALF_W-1:0]  key_high_reg;
    logic [HALF_W-1:0]  key_low_reg;
    logic               s1_valid_reg;
    item_t              s1_item_reg;
    logic               out_valid_reg;
    logic [BLOCK_W-1:0] result_reg;
    logic [BLOCK_W-1:0] result_next;
    logic               advance;

    // Move the held transaction forward when the result slot is free or drains.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Hash subkey registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.cmd        <= cmd_t'(cmd);
            s1_item_reg.block      <= {block_high, block_low};
            s1_item_reg.byte_count <= byte_count;
        end
    end

    // Multiply-accumulate and command decode; state updates on advance.
    gha_state u_state
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .item     (s1_item_reg),
        .hash_key ({key_high_reg, key_low_reg}),
        .result   (result_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_high = result_reg[BLOCK_W-1:HALF_W];
    assign result_low  = result_reg[HALF_W-1:0];

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced transaction did not reach the result register");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready && !advance)
        else $error("pipeline moved while output stalled");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("empty input register refused a transaction");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the GHASH accumulator: directed and random traffic.
module tb_top;

    import gha_pkg::*;

    // Write-port indexes that decode to no register; writes there must be dropped.
    localparam logic [INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int unsigned ITEMS_PER_PHASE = 156;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned SETTLE_CYCLES   = 6;

    // One input transaction as the stimulus queue holds it.
    typedef struct packed {
        cmd_t                 op;
        logic [HALF_W-1:0]    hi;
        logic [HALF_W-1:0]    lo;
        logic [COUNT_W-1:0]   count;
    } ghash_item_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_write   = 1'b0;
    logic [INDEX_W-1:0]   cfg_index   = '0;
    logic [HALF_W-1:0]    cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [1:0]           cmd         = CMD_ABSORB;
    logic [HALF_W-1:0]    block_high  = '0;
    logic [HALF_W-1:0]    block_low   = '0;
    logic [COUNT_W-1:0]   byte_count  = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [HALF_W-1:0]    result_high;
    logic [HALF_W-1:0]    result_low;

    // Shadow state of the block: key, running hash and byte total.
    logic [BLOCK_W-1:0]   hash_key   = '0;
    logic [BLOCK_W-1:0]   hash_acc   = '0;
    logic [TOTAL_W-1:0]   byte_total = '0;

    ghash_item_t          pending_items[$];
    logic [BLOCK_W-1:0]   expected_digests[$];
    int unsigned          queued_total    = 0;
    int unsigned          holds_requested = 0;
    int                   error_count     = 0;

    ghash_accumulator uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .block_high  (block_high),
        .block_low   (block_low),
        .byte_count  (byte_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_high (result_high),
        .result_low  (result_low)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Multiply by H in GCM bit order: bit 127 of the vector is the x^0
    // coefficient, so a right shift multiplies by x. Reduce by
    // x^128 + x^7 + x^2 + x + 1, which in this order is 0xE1 in the top byte.
    function automatic logic [BLOCK_W-1:0] gf_times_key(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] z;
        logic [BLOCK_W-1:0] v;
        z = '0;
        v = hash_key;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            if (x[BLOCK_W-1-i])
                z = z ^ v;
            if (v[0])
                v = (v >> 1) ^ {8'hE1, 120'b0};
            else
                v = v >> 1;
        end
        return z;
    endfunction

    // Advance the shadow state by one transaction and return the result it yields.
    function automatic logic [BLOCK_W-1:0] ghash_predict(input ghash_item_t it);
        logic [BLOCK_W-1:0] keep;
        int unsigned        n;
        n = (it.count > 16) ? 16 : it.count;
        case (it.op)
            CMD_ABSORB:
            begin
                // An empty block leaves the hash and the total alone.
                if (n != 0)
                begin
                    keep       = ~(BLOCK_W'(0)) << (BLOCK_W - 8 * n);
                    hash_acc   = gf_times_key(hash_acc ^ ({it.hi, it.lo} & keep));
                    byte_total = byte_total + TOTAL_W'(n);
                end
                return hash_acc;
            end
            CMD_FINISH:
            begin
                // Length block: zero AAD length, then the message length in bits.
                hash_acc = gf_times_key(hash_acc ^ {64'b0, byte_total, 3'b000});
                return hash_acc ^ {it.hi, it.lo};
            end
            CMD_CLEAR:
            begin
                hash_acc   = '0;
                byte_total = '0;
                return '0;
            end
            default:
                return hash_acc;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [HALF_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void queue_item(input cmd_t op, input logic [HALF_W-1:0] hi,
                                       input logic [HALF_W-1:0] lo, input int unsigned count);
        ghash_item_t it;
        it.op    = op;
        it.hi    = hi;
        it.lo    = lo;
        it.count = COUNT_W'(count);
        pending_items.push_back(it);
        queued_total++;
    endfunction

    // Well-formed message: optional clear, full blocks, a 1-16 byte tail, finish.
    function automatic void queue_message();
        int unsigned blocks;
        blocks = $urandom_range(0, 6);
        if ($urandom_range(0, 3) != 0)
            queue_item(CMD_CLEAR, random_word(), random_word(), $urandom_range(0, 31));
        for (int b = 0; b < blocks; b++)
        begin
            queue_item(CMD_ABSORB, random_word(), random_word(),
                       (b == blocks - 1) ? $urandom_range(1, 16) : 16);
            if ($urandom_range(0, 15) == 0)
                queue_item(CMD_ABSORB, random_word(), random_word(), 0);
        end
        queue_item(CMD_FINISH, random_word(), random_word(), $urandom_range(0, 31));
    endfunction

    // Anything the ports allow, including the unused command and oversized counts.
    function automatic void queue_noise();
        queue_item(cmd_t'($urandom_range(0, 3)), random_word(), random_word(),
                   $urandom_range(0, 31));
    endfunction

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [HALF_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_KEY_HIGH: hash_key[127:64] = data;
            REG_KEY_LOW:  hash_key[63:0]   = data;
            default:      ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_key(input logic [BLOCK_W-1:0] key);
        write_reg(REG_KEY_HIGH, key[127:64]);
        write_reg(REG_KEY_LOW, key[63:0]);
        // Hit the undecoded indexes too; the key must not move.
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, random_word());
    endtask

    // Hold until every queued transaction went in and every result came out.
    // Look between edges, once the driver and the monitor have settled.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_digests.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    ghash_item_t offered;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Predict at acceptance, so the shadow state moves in block order.
            if (in_valid && in_ready)
                expected_digests.push_back(ghash_predict(offered));

            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 || pending_items.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    offered     = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    cmd        <= offered.op;
                    block_high <= offered.hi;
                    block_low  <= offered.lo;
                    byte_count <= offered.count;
                    if (burst_left != 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        // About one burst in four runs back to back with the next one.
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, plus long hold-offs on request.
    // ------------------------------------------------------------------
    int unsigned holds_done = 0;
    int unsigned hold_left  = 0;
    int unsigned ready_mode = 0;
    int unsigned mode_left  = 0;

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_done != holds_requested)
        begin
            holds_done++;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (ready_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ~out_ready;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result with the oldest expectation.
    // ------------------------------------------------------------------
    logic [BLOCK_W-1:0] want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_digests.size() == 0)
            begin
                $error("result transaction with nothing expected: %h %h",
                       result_high, result_low);
                error_count++;
            end
            else
            begin
                want = expected_digests.pop_front();
                if (result_high !== want[127:64])
                begin
                    $error("result_high: expected %h, got %h", want[127:64], result_high);
                    error_count++;
                end
                if (result_low !== want[63:0])
                begin
                    $error("result_low: expected %h, got %h", want[63:0], result_low);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [BLOCK_W-1:0] key;
        int unsigned        start;
        bit                 paused;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under a fixed arbitrary key.
        load_key(128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
        queue_item(CMD_ABSORB, '1, '1, 16);
        queue_item(CMD_ABSORB, '1, '1, 0);          // empty block
        queue_item(CMD_ABSORB, '1, '1, 1);
        queue_item(CMD_ABSORB, '1, '1, 8);
        queue_item(CMD_ABSORB, '1, '1, 9);
        queue_item(CMD_ABSORB, '1, '1, 15);
        queue_item(CMD_ABSORB, '1, '1, 17);         // oversized count, clamp to 16
        queue_item(CMD_ABSORB, '1, '1, 31);
        queue_item(CMD_ABSORB, '0, '0, 16);
        queue_item(CMD_FINISH, '0, '0, 0);
        queue_item(CMD_FINISH, '1, '1, 31);         // count ignored on finish
        queue_item(CMD_NONE, '1, '1, 16);           // unused command
        queue_item(CMD_CLEAR, '1, '1, 31);
        queue_item(CMD_NONE, '0, '0, 0);
        queue_item(CMD_FINISH, '0, '0, 16);         // finish with zero total
        queue_item(CMD_ABSORB, random_word(), random_word(), 16);
        queue_item(CMD_ABSORB, random_word(), random_word(), 5);
        queue_item(CMD_FINISH, random_word(), random_word(), 3);
        queue_item(CMD_CLEAR, '0, '0, 0);
        drain();

        // Random phases, each under its own key, extremes included.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1:       key = '0;
                2:       key = '1;
                3:       key = {1'b1, 127'b0};      // H = 1
                4:       key = {127'b0, 1'b1};      // H = x^127
                default: key = {$urandom, $urandom, $urandom, $urandom};
            endcase
            load_key(key);

            start  = queued_total;
            paused = 1'b0;
            while (queued_total - start < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) < 7)
                    queue_message();
                else
                    queue_noise();
                // Let the sender go quiet mid-phase until all results are back.
                if (p == 4 && !paused && queued_total - start >= ITEMS_PER_PHASE / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end

            // Back-pressure: stop the receiver while a full queue keeps offering.
            if (p == 2 || p == 6)
                holds_requested++;
            drain();
        end

        if (error_count == 0 && expected_digests.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
